// ----- design/assert_macros.svh -----
// Assertion helpers for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

// ----- design/tcis_pkg.sv -----
`default_nettype none

package tcis_pkg;

    // Default table depth and the width of the point count after clamping.
    localparam int MAX_POINTS_DEF = 64;
    localparam int CNT_W          = 11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INTERP_MODE = 2'd0;
    localparam logic [1:0] CFG_POINT_COUNT = 2'd1;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Saturation limits of the Q1.30 result.
    localparam logic signed [63:0] RES_MAX = 64'sd1073741824;
    localparam logic signed [63:0] RES_MIN = -64'sd1073741824;

    typedef struct packed {
        logic               op;
        logic [5:0]         entry_index;
        logic signed [31:0] entry_cosine;
        logic [31:0]        entry_density;
        logic [31:0]        entry_cumulative;
        logic [31:0]        random_fraction;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sampled_cosine;
        logic [5:0]         bin_found;
    } t_out;

    // A classified command as it waits in the queue.
    typedef struct packed {
        logic is_sample;
        logic load_ok;
        t_in  item;
    } t_cmd;

    // Queue status seen by both sides.
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

// ----- design/tcis_divider.sv -----
`default_nettype none

module tcis_divider
    import tcis_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [63:0] i_num,
    input  wire  [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);

    logic [64:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_den;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] rem_s;

    // One restoring step per cycle, quotient bits shift in behind the numerator.
    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        rem_s  = {r_rem[63:0], r_quo[63]};
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_s >= {1'b0, r_den}) begin
                n_rem = rem_s - {1'b0, r_den};
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = rem_s;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ----- design/tcis_front.sv -----
`default_nettype none

module tcis_front
    import tcis_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire         i_start,
    input  wire  t_in   i_item,
    input  wire  t_q_status i_q,
    output logic        o_busy,
    output logic        o_push,
    output t_cmd        o_cmd
);

    // Accept while the queue has room and classify the transaction.
    always_comb begin
        o_busy          = i_q.full;
        o_push          = i_start && !i_q.full;
        o_cmd.item      = i_item;
        o_cmd.is_sample = (i_item.op == OP_SAMPLE);
        o_cmd.load_ok   = (i_item.op == OP_LOAD) &&
                          (int'(i_item.entry_index) < MAX_POINTS);
    end

endmodule

`default_nettype wire

// ----- design/tcis_queue.sv -----
`default_nettype none

module tcis_queue
    import tcis_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire  t_cmd i_cmd,
    input  wire        i_pop,
    output t_cmd       o_cmd,
    output t_q_status  o_status
);

    t_cmd       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;

    // Two-entry ring buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    assign o_cmd              = r_slot[r_rp];
    assign o_status.not_empty = (r_fill != 2'd0);
    assign o_status.full      = (r_fill == 2'd2);

endmodule

`default_nettype wire

// ----- design/tcis_back.sv -----
`default_nettype none

module tcis_back
    import tcis_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  t_cmd i_cmd,
    input  wire  t_q_status i_q,
    output logic       o_pop,
    input  wire        i_interp_mode,
    input  wire  [6:0] i_point_count,
    output logic       o_result_valid,
    output t_out       o_result
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SREQ = 4'd1;
    localparam logic [3:0] S_SCMP = 4'd2;
    localparam logic [3:0] S_RD0  = 4'd3;
    localparam logic [3:0] S_RD1  = 4'd4;
    localparam logic [3:0] S_RD2  = 4'd5;
    localparam logic [3:0] S_CALC = 4'd6;
    localparam logic [3:0] S_DIVF = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_DISC = 4'd9;
    localparam logic [3:0] S_SQRT = 4'd10;
    localparam logic [3:0] S_DEN  = 4'd11;
    localparam logic [3:0] S_DIVX = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    // Table storage, one write port and one registered read port each.
    logic [31:0] r_mu_mem  [MAX_POINTS];
    logic [31:0] r_pdf_mem [MAX_POINTS];
    logic [31:0] r_cdf_mem [MAX_POINTS];
    logic [31:0] r_rd_mu, r_rd_pdf, r_rd_cdf;
    logic [AW-1:0] rd_addr;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_k, n_k, r_nm2, n_nm2;
    logic [31:0]   r_r, n_r;
    logic          r_lin, n_lin;
    logic signed [31:0] r_mu0, n_mu0, r_mu1, n_mu1;
    logic [31:0]   r_p, n_p, r_p1, n_p1, r_cdf0, n_cdf0;
    logic [31:0]   r_dabs, n_dabs;
    logic          r_dneg, n_dneg;
    logic [62:0]   r_fa, n_fa;
    logic          r_fneg, n_fneg;
    logic [63:0]   r_p2, n_p2;
    logic [95:0]   r_mc, n_mc, r_acc, n_acc;
    logic [32:0]   r_mp, n_mp;
    logic [6:0]    r_cnt, n_cnt;
    logic [47:0]   r_root, n_root;
    logic [49:0]   r_rem, n_rem;
    logic          r_xneg, n_xneg;
    logic [63:0]   r_q, n_q;
    logic          r_ovalid, n_ovalid;
    t_out          r_out, n_out;

    logic          div_start, div_done;
    logic [63:0]   div_num, div_den, div_quo;

    logic [CNT_W-1:0]   cnt_n;
    logic signed [32:0] d_s, dp_s, dm_s;
    logic [32:0]        dp_abs, dm_abs;
    logic [95:0]        t_w, disc;
    logic [51:0]        rem_s, trial;
    logic [63:0]        den_w;
    logic signed [63:0] x_s, res_s;
    logic               opposite;

    tcis_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Read address: the next cdf during the search and for the upper entry.
    always_comb begin
        case (r_state)
            S_SREQ, S_RD1: rd_addr = r_k + AW'(1);
            default:       rd_addr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.load_ok) begin
            r_mu_mem[AW'(i_cmd.item.entry_index)]  <= i_cmd.item.entry_cosine;
            r_pdf_mem[AW'(i_cmd.item.entry_index)] <= i_cmd.item.entry_density;
            r_cdf_mem[AW'(i_cmd.item.entry_index)] <= i_cmd.item.entry_cumulative;
        end
        r_rd_mu  <= r_mu_mem[rd_addr];
        r_rd_pdf <= r_pdf_mem[rd_addr];
        r_rd_cdf <= r_cdf_mem[rd_addr];
    end

    // Point count clamped to between 2 and the table depth.
    always_comb begin
        cnt_n = CNT_W'(i_point_count);
        if (cnt_n < CNT_W'(2)) begin
            cnt_n = CNT_W'(2);
        end
        if (cnt_n > CNT_W'(MAX_POINTS)) begin
            cnt_n = CNT_W'(MAX_POINTS);
        end
    end

    // Sequencer for one transaction at a time.
    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_nm2    = r_nm2;
        n_r      = r_r;
        n_lin    = r_lin;
        n_mu0    = r_mu0;
        n_mu1    = r_mu1;
        n_p      = r_p;
        n_p1     = r_p1;
        n_cdf0   = r_cdf0;
        n_dabs   = r_dabs;
        n_dneg   = r_dneg;
        n_fa     = r_fa;
        n_fneg   = r_fneg;
        n_p2     = r_p2;
        n_mc     = r_mc;
        n_mp     = r_mp;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_root   = r_root;
        n_rem    = r_rem;
        n_xneg   = r_xneg;
        n_q      = r_q;
        n_ovalid = 1'b0;
        n_out    = r_out;
        o_pop    = 1'b0;
        div_start = 1'b0;
        div_num  = '0;
        div_den  = '0;

        d_s    = $signed({1'b0, r_r}) - $signed({1'b0, r_cdf0});
        dp_s   = $signed({1'b0, r_p1}) - $signed({1'b0, r_p});
        dm_s   = $signed({r_mu1[31], r_mu1}) - $signed({r_mu0[31], r_mu0});
        dp_abs = dp_s[32] ? 33'(-dp_s) : 33'(dp_s);
        dm_abs = dm_s[32] ? 33'(-dm_s) : 33'(dm_s);
        t_w    = r_acc >> 15;
        opposite = (r_fneg != r_dneg) && (r_fa != '0) && (r_dabs != '0);
        if (opposite) begin
            disc = ({32'd0, r_p2} < t_w) ? '0 : ({32'd0, r_p2} - t_w);
        end else begin
            disc = {32'd0, r_p2} + t_w;
        end
        rem_s  = {r_rem, r_acc[95:94]};
        trial  = {2'b00, r_root, 2'b01};
        den_w  = 64'(r_root) + 64'(r_p);
        x_s    = r_xneg ? -$signed(r_q) : $signed(r_q);
        res_s  = 64'(r_mu0) + x_s;

        case (r_state)
            S_IDLE: begin
                if (i_q.not_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_sample) begin
                        n_r     = i_cmd.item.random_fraction;
                        n_lin   = i_interp_mode;
                        n_nm2   = AW'(cnt_n - CNT_W'(2));
                        n_k     = '0;
                        n_state = S_SREQ;
                    end
                end
            end
            S_SREQ: begin
                n_state = (r_k == r_nm2) ? S_RD0 : S_SCMP;
            end
            S_SCMP: begin
                if (r_r < r_rd_cdf) begin
                    n_state = S_RD0;
                end else begin
                    n_k     = r_k + AW'(1);
                    n_state = S_SREQ;
                end
            end
            S_RD0: begin
                n_state = S_RD1;
            end
            S_RD1: begin
                n_mu0   = r_rd_mu;
                n_p     = r_rd_pdf;
                n_cdf0  = r_rd_cdf;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_mu1   = r_rd_mu;
                n_p1    = r_rd_pdf;
                n_state = S_CALC;
            end
            S_CALC: begin
                n_dneg = d_s[32];
                n_dabs = d_s[32] ? 32'(-d_s) : 32'(d_s);
                n_q    = '0;
                n_xneg = d_s[32];
                if (!r_lin || dp_s == '0 || dm_s == '0) begin
                    // Histogram offset, also the flat-slope fallback.
                    if (r_p == '0) begin
                        n_state = S_FIN;
                    end else begin
                        div_start = 1'b1;
                        div_num   = 64'(d_s[32] ? 33'(-d_s) : 33'(d_s)) << 14;
                        div_den   = 64'(r_p);
                        n_state   = S_DIVX;
                    end
                end else begin
                    div_start = 1'b1;
                    div_num   = 64'(dp_abs) << 30;
                    div_den   = 64'(dm_abs);
                    n_fneg    = dp_s[32] ^ dm_s[32];
                    n_state   = S_DIVF;
                end
            end
            S_DIVF: begin
                if (div_done) begin
                    n_fa    = 63'(div_quo);
                    n_fneg  = r_fneg && (div_quo != '0);
                    n_p2    = 64'(r_p) * 64'(r_p);
                    n_mc    = 96'(div_quo[62:0]);
                    n_mp    = 33'(r_dabs);
                    n_acc   = '0;
                    n_cnt   = 7'd33;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Shift-and-add product of slope magnitude and offset.
                if (r_cnt == '0) begin
                    n_state = S_DISC;
                end else begin
                    if (r_mp[0]) begin
                        n_acc = r_acc + r_mc;
                    end
                    n_mc  = r_mc << 1;
                    n_mp  = r_mp >> 1;
                    n_cnt = r_cnt - 7'd1;
                end
            end
            S_DISC: begin
                n_acc   = disc;
                n_root  = '0;
                n_rem   = '0;
                n_cnt   = 7'd48;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // Restoring square root, two radicand bits per cycle.
                if (r_cnt == '0) begin
                    n_state = S_DEN;
                end else begin
                    if (rem_s >= trial) begin
                        n_rem  = 50'(rem_s - trial);
                        n_root = {r_root[46:0], 1'b1};
                    end else begin
                        n_rem  = 50'(rem_s);
                        n_root = {r_root[46:0], 1'b0};
                    end
                    n_acc = r_acc << 2;
                    n_cnt = r_cnt - 7'd1;
                end
            end
            S_DEN: begin
                if (den_w == '0) begin
                    n_state = S_FIN;
                end else begin
                    div_start = 1'b1;
                    div_num   = 64'(r_dabs) << 15;
                    div_den   = den_w;
                    n_state   = S_DIVX;
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    n_q     = div_quo;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_ovalid = 1'b1;
                if (res_s > RES_MAX) begin
                    n_out.sampled_cosine = 32'(RES_MAX);
                end else if (res_s < RES_MIN) begin
                    n_out.sampled_cosine = 32'(RES_MIN);
                end else begin
                    n_out.sampled_cosine = 32'(res_s);
                end
                n_out.bin_found = 6'(r_k);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_k    <= n_k;
        r_nm2  <= n_nm2;
        r_r    <= n_r;
        r_lin  <= n_lin;
        r_mu0  <= n_mu0;
        r_mu1  <= n_mu1;
        r_p    <= n_p;
        r_p1   <= n_p1;
        r_cdf0 <= n_cdf0;
        r_dabs <= n_dabs;
        r_dneg <= n_dneg;
        r_fa   <= n_fa;
        r_fneg <= n_fneg;
        r_p2   <= n_p2;
        r_mc   <= n_mc;
        r_mp   <= n_mp;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_root <= n_root;
        r_rem  <= n_rem;
        r_xneg <= n_xneg;
        r_q    <= n_q;
        r_out  <= n_out;
    end

    assign o_result_valid = r_ovalid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

// ----- design/tabular_cdf_inversion_sampler_unit.sv -----
// Tabular inverse-CDF sampler. Loads with an in-range index write one table
// entry and produce no result; a sample produces one result, shown for a
// single cycle with o_result_valid high, and the receiver cannot stall it.
// Accepted transactions wait in a two-entry queue and busy rises only when
// that queue is full. A load leaves the queue as soon as the back end is idle.
// A sample goes through the pop, bin search, table reads and setup.
// Histogram mode then divides in the shared divider and forms the result; a
// zero density skips the divider. Linear-linear mode does the slope division,
// the shift-add multiplication, the discriminant, the square root, the
// denominator, the second division in the divider and the forming of the
// result. The result strobe comes in the cycle after the result is formed.
// Configuration writes are always ready and must only be made while the
// block is idle.
`default_nettype none

`include "assert_macros.svh"

module tabular_cdf_inversion_sampler_unit
    import tcis_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire  t_in  i_item,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [1:0] i_cfg_index,
    input  wire  [6:0] i_cfg_data,
    output logic       o_result_valid,
    output t_out       o_result
);

    logic      r_interp_mode;
    logic [6:0] r_point_count;
    logic      push, pop;
    t_cmd      front_cmd, q_cmd;
    t_q_status q_status;
    logic      res_in_range;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode <= 1'b1;
            r_point_count <= 7'd2;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INTERP_MODE: r_interp_mode <= i_cfg_data[0];
                CFG_POINT_COUNT: r_point_count <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    tcis_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_q     (q_status),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    tcis_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    tcis_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_q            (q_status),
        .o_pop          (pop),
        .i_interp_mode  (r_interp_mode),
        .i_point_count  (r_point_count),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // The sampled cosine lies within [-1, 1] in Q1.30.
    assign res_in_range = (o_result.sampled_cosine <= 32'sd1073741824) &&
                          (o_result.sampled_cosine >= -32'sd1073741824);

    // Results are single-cycle strobes and always within [-1, 1].
    `ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    `ASSERT_ALWAYS(a_result_range, i_clk, i_rst_n, !o_result_valid || res_in_range)
    // The back end never drains an empty queue.
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !pop || q_status.not_empty)

endmodule

`default_nettype wire
